### hdl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types, constants and helper functions of the shaped dither quantiser.
// ----------------------------------------------------------------------------
`default_nettype none

package sdq_pkg;

	// Filter and register geometry.
	localparam int TAPS       = 10;
	localparam int COEF_REGS  = 5;
	localparam int PAIRS      = (TAPS + 1) / 2;
	localparam int CFG_W      = 32;
	localparam int CFG_ADDR_W = 3;

	// Datapath widths.
	localparam int IN_W    = 32;
	localparam int OUT_W   = 24;
	localparam int COEF_W  = 16;
	localparam int PROD_W  = 48;
	localparam int PAIR_W  = PROD_W + 1;
	localparam int ACC_W   = 52;
	localparam int SHIFT_A = 22;
	localparam int DITH_W  = ACC_W - SHIFT_A;
	localparam int TERM_W  = 48;
	localparam int TOTAL_W = 49;
	localparam int SHIFT_Y = 24;
	localparam int Y_W     = TOTAL_W - SHIFT_Y;
	localparam int FILL_K_W = 23;
	localparam int FILL_P_W = IN_W + FILL_K_W;
	localparam int FILL_W   = FILL_P_W - IN_W;
	localparam int M_DATA_W = 32;

	// Generator seed after reset, and the zero-input fill gain.
	localparam logic [IN_W-1:0]     SEED_DEFAULT = 32'd2463534242;
	localparam logic [FILL_K_W-1:0] ZERO_FILL_K  = 23'd7132662;

	// Output range.
	localparam logic signed [Y_W-1:0] OUT_MAX = 25'sd8388607;
	localparam logic signed [Y_W-1:0] OUT_MIN = -25'sd8388608;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_COEF_PAIR_0 = 3'd0,
		REG_COEF_PAIR_1 = 3'd1,
		REG_COEF_PAIR_2 = 3'd2,
		REG_COEF_PAIR_3 = 3'd3,
		REG_COEF_PAIR_4 = 3'd4,
		REG_NOISE_SEED  = 3'd5
	} cfg_reg_t;

	typedef logic [CFG_W-1:0] coef_pair_t [COEF_REGS];

	// One 13/17/5 xorshift step.
	function automatic logic [IN_W-1:0] xorshift_step(input logic [IN_W-1:0] x);
		logic [IN_W-1:0] a;
		logic [IN_W-1:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	// Signed Q2.14 coefficient of one tap; taps past the registers weigh zero.
	function automatic logic signed [COEF_W-1:0] tap_coef(input coef_pair_t pairs,
			input int t);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if ((t / 2) < COEF_REGS) begin
			if ((t % 2) == 1) begin
				c = $signed(pairs[t / 2][CFG_W-1:COEF_W]);
			end else begin
				c = $signed(pairs[t / 2][COEF_W-1:0]);
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/shaped_dither_quantizer.sv
// ----------------------------------------------------------------------------
// shaped_dither_quantizer
// Requantises 32-bit audio samples to 24 bits with FIR-shaped xorshift dither.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_t* stream, one 32-bit two's complement word each,
//   and leave on the m_t* stream as a 24-bit floored, saturated sample with a
//   clip flag. Coefficients and the generator seed are written through the
//   cfg_we / cfg_addr / cfg_data port while the stream is idle; a seed write
//   reloads the generator at once (a zero seed loads the default instead).
//   Each accepted word pushes the current generator word into a ten-deep
//   history, which feeds ten 32x16 multipliers, one per tap.
//   From acceptance to m_tvalid a word passes through five registers: input
//   register, tap products, pair sums, final tap sum, then add, floor and
//   saturate into the output register. Throughput is one word per cycle while
//   the receiver does not stall.
//   Reset clears the history and coefficients, loads the default seed and
//   empties the pipeline. When the receiver stalls, each stage holds only if
//   the stage after it is full, so bubbles close up and s_tready falls only
//   once all five stages hold words.
// ----------------------------------------------------------------------------
`default_nettype none

module shaped_dither_quantizer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [sdq_pkg::IN_W-1:0]          s_tdata,  // [31:0] sample_in
	// Output stream.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [sdq_pkg::M_DATA_W-1:0]           m_tdata,  // [23:0] sample_out, [24] clipped
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [sdq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [sdq_pkg::CFG_W-1:0]         cfg_data
);

	// Configuration and generator state.
	sdq_pkg::coef_pair_t            coef_q;
	logic [sdq_pkg::IN_W-1:0]       rng_q;
	logic [sdq_pkg::IN_W-1:0]       history_q [sdq_pkg::TAPS];

	// Pipeline valids and load enables.
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;
	logic accept;

	// Pipeline payload.
	logic signed [sdq_pkg::IN_W-1:0]    sample_s1;
	logic signed [sdq_pkg::PROD_W-1:0]  prod_s2 [sdq_pkg::TAPS];
	logic signed [sdq_pkg::TERM_W-1:0]  term_s2, term_s3, term_s4;
	logic signed [sdq_pkg::PAIR_W-1:0]  pair_s3 [sdq_pkg::PAIRS];
	logic signed [sdq_pkg::ACC_W-1:0]   acc_s4;
	logic signed [sdq_pkg::OUT_W-1:0]   sample_out_q;
	logic                               clipped_q;

	// Combinational stage results.
	logic signed [sdq_pkg::PROD_W:0]     prod_full_c [sdq_pkg::TAPS];
	logic [sdq_pkg::FILL_P_W-1:0]        fill_full_c;
	logic signed [sdq_pkg::TERM_W-1:0]   term_c;
	logic signed [sdq_pkg::PAIR_W-1:0]   pair_c [sdq_pkg::PAIRS];
	logic signed [sdq_pkg::ACC_W-1:0]    acc_c;
	logic signed [sdq_pkg::DITH_W-1:0]   dither_c;
	logic signed [sdq_pkg::TOTAL_W-1:0]  total_c;
	logic signed [sdq_pkg::Y_W-1:0]      y_c;
	logic signed [sdq_pkg::OUT_W-1:0]    sat_c;
	logic                                clip_c;

	// A stage loads when it is empty or its word moves on.
	assign en_out   = !out_valid_q || m_tready;
	assign en_s4    = !valid_s4 || en_out;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;
	assign accept   = s_tvalid && en_s1;

	// Control registers: valids, coefficients, generator and noise history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			rng_q       <= sdq_pkg::SEED_DEFAULT;
			for (int r = 0; r < sdq_pkg::COEF_REGS; r++) begin
				coef_q[r] <= '0;
			end
			for (int t = 0; t < sdq_pkg::TAPS; t++) begin
				history_q[t] <= '0;
			end
		end else begin
			if (en_s1)  valid_s1    <= s_tvalid;
			if (en_s2)  valid_s2    <= valid_s1;
			if (en_s3)  valid_s3    <= valid_s2;
			if (en_s4)  valid_s4    <= valid_s3;
			if (en_out) out_valid_q <= valid_s4;

			// The current generator word joins the history as the newest tap.
			if (accept) begin
				history_q[0] <= rng_q;
				for (int t = 1; t < sdq_pkg::TAPS; t++) begin
					history_q[t] <= history_q[t-1];
				end
				rng_q <= sdq_pkg::xorshift_step(rng_q);
			end

			if (cfg_we) begin
				case (cfg_addr)
					sdq_pkg::REG_COEF_PAIR_0: coef_q[0] <= cfg_data;
					sdq_pkg::REG_COEF_PAIR_1: coef_q[1] <= cfg_data;
					sdq_pkg::REG_COEF_PAIR_2: coef_q[2] <= cfg_data;
					sdq_pkg::REG_COEF_PAIR_3: coef_q[3] <= cfg_data;
					sdq_pkg::REG_COEF_PAIR_4: coef_q[4] <= cfg_data;
					sdq_pkg::REG_NOISE_SEED: begin
						rng_q <= (cfg_data != '0) ? cfg_data : sdq_pkg::SEED_DEFAULT;
					end
					default: ;
				endcase
			end
		end
	end

	// Tap products and the sample term; the newest tap is the pre-step word.
	always_comb begin
		for (int t = 0; t < sdq_pkg::TAPS; t++) begin
			prod_full_c[t] = $signed({1'b0, history_q[t]}) *
				sdq_pkg::tap_coef(coef_q, t);
		end
		fill_full_c = sdq_pkg::FILL_P_W'(history_q[0]) *
			sdq_pkg::FILL_P_W'(sdq_pkg::ZERO_FILL_K);
		if (sample_s1 == '0) begin
			term_c = $signed(sdq_pkg::TERM_W'(
				fill_full_c[sdq_pkg::FILL_P_W-1:sdq_pkg::IN_W]));
		end else begin
			term_c = {sample_s1, 16'b0};
		end
	end

	// Pairwise sums of the tap products.
	always_comb begin
		for (int p = 0; p < sdq_pkg::PAIRS; p++) begin
			if ((2 * p + 1) < sdq_pkg::TAPS) begin
				pair_c[p] = sdq_pkg::PAIR_W'(prod_s2[2*p]) +
					sdq_pkg::PAIR_W'(prod_s2[2*p+1]);
			end else begin
				pair_c[p] = sdq_pkg::PAIR_W'(prod_s2[2*p]);
			end
		end
	end

	// Final tap sum.
	always_comb begin
		acc_c = '0;
		for (int p = 0; p < sdq_pkg::PAIRS; p++) begin
			acc_c = acc_c + sdq_pkg::ACC_W'(pair_s3[p]);
		end
	end

	// Floor the dither to Q.24, add the sample term, floor again and saturate.
	always_comb begin
		dither_c = acc_s4[sdq_pkg::ACC_W-1:sdq_pkg::SHIFT_A];
		total_c  = sdq_pkg::TOTAL_W'(term_s4) + sdq_pkg::TOTAL_W'(dither_c);
		y_c      = total_c[sdq_pkg::TOTAL_W-1:sdq_pkg::SHIFT_Y];
		if (y_c > sdq_pkg::OUT_MAX) begin
			sat_c  = sdq_pkg::OUT_W'(sdq_pkg::OUT_MAX);
			clip_c = 1'b1;
		end else if (y_c < sdq_pkg::OUT_MIN) begin
			sat_c  = sdq_pkg::OUT_W'(sdq_pkg::OUT_MIN);
			clip_c = 1'b1;
		end else begin
			sat_c  = y_c[sdq_pkg::OUT_W-1:0];
			clip_c = 1'b0;
		end
	end

	// Payload registers of every stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= $signed(s_tdata);
		end
		if (en_s2 && valid_s1) begin
			for (int t = 0; t < sdq_pkg::TAPS; t++) begin
				prod_s2[t] <= prod_full_c[t][sdq_pkg::PROD_W-1:0];
			end
			term_s2 <= term_c;
		end
		if (en_s3 && valid_s2) begin
			for (int p = 0; p < sdq_pkg::PAIRS; p++) begin
				pair_s3[p] <= pair_c[p];
			end
			term_s3 <= term_s2;
		end
		if (en_s4 && valid_s3) begin
			acc_s4  <= acc_c;
			term_s4 <= term_s3;
		end
		if (en_out && valid_s4) begin
			sample_out_q <= sat_c;
			clipped_q    <= clip_c;
		end
	end

	// Output stream.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, clipped_q, sample_out_q};

endmodule

`default_nettype wire

### test/shaped_dither_quantizer_test.sv
// ----------------------------------------------------------------------------
// shaped_dither_quantizer_test
// Self-checking bench for the shaped dither quantiser. Each accepted sample is
// run through a cycle-free predictor of the dithered, floored and saturated
// 24-bit result; each output word is checked field by field against the
// oldest prediction. Directed tests cover reset state, full-scale taps, seed
// loading and unused register indexes, followed by a long random stream with
// changing coefficients and random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module shaped_dither_quantizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sdq_pkg::*;

	// Indexes that decode to no register; writes there must be dropped.
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

	localparam logic [31:0] DEFAULT_SEED = 32'd2463534242;
	localparam logic [63:0] FILL_GAIN    = 64'd7132662;
	localparam longint      SAT_HIGH     = 64'sd8388607;
	localparam longint      SAT_LOW      = -64'sd8388608;
	localparam int          RANDOM_ITEMS = 1000;

	typedef struct packed {
		logic        clipped;
		logic [23:0] sample_out;
	} quant_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;      // [31:0] sample_in
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;           // [23:0] sample_out, [24] clipped
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	// Mirror of the quantiser state.
	logic [31:0] coef_regs [COEF_REGS];
	logic [31:0] noise_hist [TAPS];
	logic [31:0] noise_word;

	quant_result_t pending_results [$];
	int            error_count = 0;
	bit            idle_on = 1'b1;

	shaped_dither_quantizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	// Predict one result and advance the mirrored history and generator.
	function automatic quant_result_t quantize_sample(input logic [31:0] smp);
		longint              total;
		longint              taps_sum;
		longint              y;
		logic [63:0]         fill_prod;
		logic signed [15:0]  c;
		quant_result_t       r;
		if (smp == 32'd0) begin
			// Silence is replaced by a small fill drawn from the generator.
			fill_prod = 64'(noise_word) * FILL_GAIN;
			total = longint'(fill_prod >> 32);
		end else begin
			total = longint'($signed(smp)) * 65536;
		end
		for (int t = TAPS - 1; t > 0; t--) begin
			noise_hist[t] = noise_hist[t - 1];
		end
		noise_hist[0] = noise_word;
		taps_sum = 0;
		for (int t = 0; t < TAPS; t++) begin
			if (t / 2 >= COEF_REGS) begin
				c = '0;
			end else if (t % 2 == 1) begin
				c = coef_regs[t / 2][31:16];
			end else begin
				c = coef_regs[t / 2][15:0];
			end
			taps_sum += longint'(noise_hist[t]) * longint'(c);
		end
		total += taps_sum >>> 22;
		y = total >>> 24;
		r.clipped = 1'b0;
		if (y > SAT_HIGH) begin
			y = SAT_HIGH;
			r.clipped = 1'b1;
		end else if (y < SAT_LOW) begin
			y = SAT_LOW;
			r.clipped = 1'b1;
		end
		r.sample_out = y[23:0];
		noise_word ^= noise_word << 13;
		noise_word ^= noise_word >> 17;
		noise_word ^= noise_word << 5;
		return r;
	endfunction

	// Present one sample and record its prediction once the word is taken.
	task automatic send_sample(input logic [31:0] smp);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_results.push_back(quantize_sample(smp));
	endtask

	// Stop sending and hold off until every predicted word has arrived.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Register write, only ever issued with the pipeline empty.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < COEF_REGS) begin
			coef_regs[idx] = val;
		end else if (idx == REG_NOISE_SEED) begin
			noise_word = (val != 0) ? val : DEFAULT_SEED;
		end
	endtask

	// Mostly ordinary audio, with silence, tiny values and near full scale.
	function automatic logic [31:0] pick_sample();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = 32'($urandom_range(0, 511)) - 32'd256;
			2: v = 32'h7FFF_FFFF - 32'($urandom_range(0, 4095));
			3: v = 32'h8000_0000 + 32'($urandom_range(0, 4095));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Coefficient pair: fully random, gentle shaping taps or silence.
	function automatic logic [31:0] pick_coef_pair();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0, 1: v = $urandom;
			2: v = {16'($urandom_range(0, 8191)) - 16'd4096,
					16'($urandom_range(0, 8191)) - 16'd4096};
			default: v = '0;
		endcase
		return v;
	endfunction

	// Reset values: no dither, so the output is the plain floor of the input.
	task automatic test_reset_state();
		send_sample(32'd0);
		send_sample(32'd1);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'd256);
		send_sample(32'hFFFF_FF00);
		send_sample(32'hFFFF_FEFF);
		drain();
	endtask

	// Largest positive and negative taps drive the output into saturation.
	task automatic test_full_scale_taps();
		for (int k = 0; k < COEF_REGS; k++) begin
			write_reg(3'(REG_COEF_PAIR_0 + k), 32'h7FFF_7FFF);
		end
		repeat (3) send_sample(32'h7FFF_FFFF);
		send_sample(32'd0);
		send_sample(32'h8000_0000);
		for (int k = 0; k < COEF_REGS; k++) begin
			write_reg(3'(REG_COEF_PAIR_0 + k), 32'h8000_8000);
		end
		repeat (3) send_sample(32'h8000_0000);
		send_sample(32'd0);
		send_sample(32'h7FFF_FFFF);
		drain();
	endtask

	// Seed loading, the zero seed fallback and writes to unused indexes.
	task automatic test_seed_loading();
		write_reg(REG_COEF_PAIR_0, 32'h2000_E000);
		write_reg(REG_NOISE_SEED, 32'd0);
		send_sample(32'd0);
		send_sample(32'h0000_1234);
		write_reg(REG_NOISE_SEED, 32'd1);
		send_sample(32'd0);
		write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
		send_sample(32'd0);
		write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_7, 32'h5A5A_5A5A);
		send_sample(32'hDEAD_BEEF);
		send_sample(32'd0);
		drain();
	endtask

	// Long random stream; each phase loads fresh taps and often a new seed.
	task automatic test_random_stream();
		int per_phase;
		per_phase = RANDOM_ITEMS / 5;
		for (int phase = 0; phase < 5; phase++) begin
			for (int k = 0; k < COEF_REGS; k++) begin
				write_reg(3'(REG_COEF_PAIR_0 + k), pick_coef_pair());
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_NOISE_SEED, $urandom);
			end
			// One phase runs flat out with no gaps on either side.
			idle_on = (phase != 2);
			for (int i = 0; i < per_phase; i++) begin
				send_sample(pick_sample());
			end
			drain();
		end
		idle_on = 1'b1;
	endtask

	// Compare each output word with the oldest prediction.
	always @(posedge clk) begin
		quant_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[23:0] !== want.sample_out) begin
					$display("%0t: sample_out expected %0d actual %0d", $time,
						$signed(want.sample_out), $signed(m_tdata[23:0]));
					error_count++;
				end
				if (m_tdata[24] !== want.clipped) begin
					$display("%0t: clipped expected %b actual %b", $time,
						want.clipped, m_tdata[24]);
					error_count++;
				end
				if (m_tdata[31:25] !== 7'd0) begin
					$display("%0t: padding expected 0 actual %h", $time, m_tdata[31:25]);
					error_count++;
				end
			end
		end
	end

	// The receiver stalls at random, except in the flat-out phase.
	always @(negedge clk) begin
		m_tready <= idle_on ? ($urandom_range(0, 99) >= 14) : 1'b1;
	end

	initial begin
		foreach (coef_regs[k]) begin
			coef_regs[k] = '0;
		end
		foreach (noise_hist[k]) begin
			noise_hist[k] = '0;
		end
		noise_word = DEFAULT_SEED;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_full_scale_taps();
		test_seed_loading();
		test_random_stream();

		drain();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog against a stuck handshake.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### shaped_dither_quantizer.f
hdl/sdq_pkg.sv
hdl/shaped_dither_quantizer.sv
test/shaped_dither_quantizer_test.sv
